@@ sv/bkms_pkg.sv @@
// ----------------------------------------------------------------------------
// bkms_pkg
// Shared types, constants and the FNV-1 step for the bottom-k sketch block.
// ----------------------------------------------------------------------------
`default_nettype none

package bkms_pkg;

    // FNV-1 32-bit constants
    localparam logic [31:0] HASH_MULT = 32'd16777619;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

    // Field widths
    localparam int CODE_W = 32;
    localparam int HASH_W = 32;
    localparam int SIZE_W = 6;
    localparam int RANK_W = 5;

    // Default sketch capacity
    localparam int MAX_SKETCH_DEF = 32;

    // Queue between the hash front and the sorting back
    localparam int QDEPTH = 8;
    localparam int QAW    = 3;
    localparam int QCW    = 4;

    // Number of hash steps, one byte each
    localparam int NSTEP = 4;

    // One hashed item in flight
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              last;
    } t_hash_item;

    // One FNV-1 round: multiply by the prime, then xor the byte
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0]        b);
        logic [HASH_W-1:0] prod;
        prod     = h * HASH_MULT;
        fnv_step = prod ^ {24'd0, b};
    endfunction

endpackage

`default_nettype wire

@@ sv/bkms_front.sv @@
// ----------------------------------------------------------------------------
// bkms_front
// Input side: four-stage FNV-1 hash pipeline with credit flow control
// toward the item queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bkms_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [bkms_pkg::CODE_W-1:0]  i_code,
    input  wire logic                         i_last,
    input  wire logic                         i_pop,
    output logic                              o_ready,
    output logic                              o_push,
    output bkms_pkg::t_hash_item              o_item
);

    localparam int NS = bkms_pkg::NSTEP;

    logic [NS-1:0]                    r_vld;
    logic [bkms_pkg::HASH_W-1:0]      r_h    [NS];
    logic [bkms_pkg::CODE_W-1:0]      r_code [NS];
    logic [NS-1:0]                    r_last;
    logic [bkms_pkg::QCW-1:0]         r_pend, n_pend;
    logic                             w_acc;

    // Credit: items in the pipe plus items queued never exceed queue depth
    assign o_ready = (r_pend < bkms_pkg::QCW'(bkms_pkg::QDEPTH));
    assign w_acc   = i_valid & o_ready;

    always_comb begin
        n_pend = r_pend;
        if (w_acc && !i_pop) begin
            n_pend = r_pend + 1'b1;
        end else if (!w_acc && i_pop) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_vld  <= '0;
        end else begin
            r_pend <= n_pend;
            r_vld  <= {r_vld[NS-2:0], w_acc};
        end
    end

    // Hash stages, one byte each, lowest byte first
    always_ff @(posedge i_clk) begin
        r_h[0]    <= bkms_pkg::fnv_step(bkms_pkg::FNV_BASIS, i_code[7:0]);
        r_code[0] <= i_code;
        r_last[0] <= i_last;
        for (int s = 1; s < NS; s++) begin
            r_h[s]    <= bkms_pkg::fnv_step(r_h[s-1], r_code[s-1][8*s +: 8]);
            r_code[s] <= r_code[s-1];
            r_last[s] <= r_last[s-1];
        end
    end

    assign o_push      = r_vld[NS-1];
    assign o_item.hash = r_h[NS-1];
    assign o_item.last = r_last[NS-1];

endmodule

`default_nettype wire

@@ sv/bkms_fifo.sv @@
// ----------------------------------------------------------------------------
// bkms_fifo
// Short item queue between the hash front and the sorting back.
// ----------------------------------------------------------------------------
`default_nettype none

module bkms_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire bkms_pkg::t_hash_item  i_item,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output logic                       o_full,
    output bkms_pkg::t_hash_item       o_item
);

    bkms_pkg::t_hash_item             r_mem [bkms_pkg::QDEPTH];
    logic [bkms_pkg::QAW-1:0]         r_wp, r_rp;
    logic [bkms_pkg::QCW-1:0]         r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == bkms_pkg::QCW'(bkms_pkg::QDEPTH));
    assign o_item  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/bkms_back.sv @@
// ----------------------------------------------------------------------------
// bkms_back
// Sorted store of the smallest hashes with parallel compare-and-shift
// insertion, and the sketch readout that shifts the store out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bkms_back #(
    parameter int MAX_SKETCH = bkms_pkg::MAX_SKETCH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [bkms_pkg::SIZE_W-1:0]  i_size,
    input  wire logic                         i_q_valid,
    input  wire bkms_pkg::t_hash_item         i_q_item,
    output logic                              o_q_pop,
    input  wire logic                         i_m_ready,
    output logic                              o_m_valid,
    output logic [bkms_pkg::HASH_W-1:0]       o_hash,
    output logic [bkms_pkg::RANK_W-1:0]       o_rank,
    output logic                              o_last
);

    localparam int CW = $clog2(MAX_SKETCH + 1);
    localparam int HW = bkms_pkg::HASH_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [HW-1:0]        r_store [MAX_SKETCH];
    logic [HW-1:0]        n_store [MAX_SKETCH];
    logic [HW-1:0]        w_ins   [MAX_SKETCH];
    logic [HW-1:0]        w_shift [MAX_SKETCH];
    logic [MAX_SKETCH:0]  w_lt;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        w_eff;
    logic                 w_final;
    logic                 r_ov, n_ov;
    logic [HW-1:0]        r_hash, n_hash;
    logic [CW-1:0]        r_rank, n_rank;
    logic                 r_last, n_last;

    // Effective sketch size: zero reads as one, saturates at capacity
    always_comb begin
        if (i_size == '0) begin
            w_eff = CW'(1);
        end else if (7'(i_size) > 7'(MAX_SKETCH)) begin
            w_eff = CW'(MAX_SKETCH);
        end else begin
            w_eff = CW'(i_size);
        end
    end

    assign w_final = (r_idx == w_eff - 1'b1);

    // Per-entry insert and shift-out values
    assign w_lt[0] = 1'b0;
    for (genvar k = 0; k < MAX_SKETCH; k++) begin : g_cell
        assign w_lt[k+1] = (i_q_item.hash < r_store[k]);
        if (k == 0) begin : g_head
            assign w_ins[k] = w_lt[k+1] ? i_q_item.hash : r_store[k];
        end else begin : g_body
            // equal entries stay ahead of the new hash
            assign w_ins[k] = !w_lt[k+1] ? r_store[k] :
                              (w_lt[k] ? r_store[k-1] : i_q_item.hash);
        end
        if (k == MAX_SKETCH - 1) begin : g_tail
            assign w_shift[k] = bkms_pkg::ALL_ONES;
        end else begin : g_mid
            assign w_shift[k] = r_store[k+1];
        end
    end

    // Control
    always_comb begin
        n_state = r_state;
        n_store = r_store;
        n_idx   = r_idx;
        n_ov    = r_ov & ~i_m_ready;
        n_hash  = r_hash;
        n_rank  = r_rank;
        n_last  = r_last;
        o_q_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_store = w_ins;
                    if (i_q_item.last) begin
                        n_state = ST_EMIT;
                        n_idx   = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ov || i_m_ready) begin
                    n_ov   = 1'b1;
                    n_hash = r_store[0];
                    n_rank = r_idx;
                    n_last = w_final;
                    if (w_final) begin
                        for (int k = 0; k < MAX_SKETCH; k++) begin
                            n_store[k] = bkms_pkg::ALL_ONES;
                        end
                        n_state = ST_IDLE;
                    end else begin
                        n_store = w_shift;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            for (int k = 0; k < MAX_SKETCH; k++) begin
                r_store[k] <= bkms_pkg::ALL_ONES;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_idx   <= n_idx;
            r_store <= n_store;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
        r_rank <= n_rank;
        r_last <= n_last;
    end

    assign o_m_valid = r_ov;
    assign o_hash    = r_hash;
    assign o_rank    = bkms_pkg::RANK_W'(r_rank);
    assign o_last    = r_last;

endmodule

`default_nettype wire

@@ sv/bottom_k_minhash_sketch.sv @@
// ----------------------------------------------------------------------------
// bottom_k_minhash_sketch
// Bottom-k MinHash sketch of a stream of k-mer codes using 32-bit FNV-1.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: i_s_tdata carries one 32-bit k-mer code per item; i_s_tlast
//   marks the last code of a set. Master stream: one item per sketch entry in
//   ascending hash order, o_m_tlast on the final entry; unfilled places read
//   as all ones. i_cfg_we/i_cfg_wdata set the sketch size (reset 32); write
//   it only while the block is idle.
//   A code is hashed in a four-stage pipeline, queued, then inserted into the
//   sorted store, so codes stream in at one per cycle while o_s_tready is high.
//   On the last code of a set the store is shifted out one entry per cycle while
//   i_m_tready is high. While the readout runs, new codes still enter until
//   the pipeline and the eight-entry queue together hold eight codes.
//   The output register holds its item while i_m_tready is low; readout and
//   then the queue and the input stall behind it.
//   Reset (synchronous, active low) empties the pipeline and queue, sets the
//   store to all ones and the sketch size to 32.
// ----------------------------------------------------------------------------
`default_nettype none

module bottom_k_minhash_sketch #(
    parameter int MAX_SKETCH = bkms_pkg::MAX_SKETCH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [31:0]                  i_s_tdata,   // [31:0] kmer_code
    input  wire logic                         i_s_tlast,   // end_of_set
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [39:0]                       o_m_tdata,   // [31:0] hash_value, [36:32] rank
    output logic                              o_m_tlast,   // last_entry
    input  wire logic                         i_cfg_we,
    input  wire logic [bkms_pkg::SIZE_W-1:0]  i_cfg_wdata  // sketch_size
);

    logic [bkms_pkg::SIZE_W-1:0]  r_size;
    logic                         w_push, w_pop, w_qvalid, w_qfull;
    bkms_pkg::t_hash_item         w_fitem, w_qitem;
    logic [bkms_pkg::HASH_W-1:0]  w_hash;
    logic [bkms_pkg::RANK_W-1:0]  w_rank;

    // Sketch size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= bkms_pkg::SIZE_W'(32);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    bkms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_code  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_pop   (w_pop),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_item  (w_fitem)
    );

    bkms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_full  (w_qfull),
        .o_item  (w_qitem)
    );

    bkms_back #(
        .MAX_SKETCH (MAX_SKETCH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_size    (r_size),
        .i_q_valid (w_qvalid),
        .i_q_item  (w_qitem),
        .o_q_pop   (w_pop),
        .i_m_ready (i_m_tready),
        .o_m_valid (o_m_tvalid),
        .o_hash    (w_hash),
        .o_rank    (w_rank),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {3'd0, w_rank, w_hash};

    // Credit scheme must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!w_qfull || w_pop))
        else $error("item queue overflow");

    // Queue is only drained when it holds an item
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("item queue underflow");

    // Ranks count up within a sketch
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) ##1 o_m_tvalid |->
        (w_rank == $past(w_rank) + 1'b1))
        else $error("sketch rank did not advance");

    // Output register is empty after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
